// ===== hdl/cad_pkg.sv =====
// Shared types and constants for the credit admission decision core.
// Holds register indexes, verdict/reason codes, the ppm divider constants
// and the pipeline stage map. No dependencies.
`timescale 1ns / 1ps

package cad_pkg;

  // Field widths
  localparam int CREDIT_WIDTH    = 64;
  localparam int PPM_WIDTH       = 20;
  localparam int TAG_WIDTH       = 64;
  localparam int TIME_WIDTH      = 64;
  localparam int STATE_WIDTH     = 3;
  localparam int VERDICT_WIDTH   = 2;
  localparam int REASON_WIDTH    = 3;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OC_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OC_FIXED  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OC_PPM    = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRANT_TTL = 2'd3;

  // Device states
  localparam logic [STATE_WIDTH-1:0] DEV_AVAILABLE   = 3'd0;
  localparam logic [STATE_WIDTH-1:0] DEV_DRAINING    = 3'd1;
  localparam logic [STATE_WIDTH-1:0] DEV_MAINTENANCE = 3'd2;
  localparam logic [STATE_WIDTH-1:0] DEV_UNAVAILABLE = 3'd3;

  // Verdicts
  localparam logic [VERDICT_WIDTH-1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [VERDICT_WIDTH-1:0] VERDICT_DELAY  = 2'd1;
  localparam logic [VERDICT_WIDTH-1:0] VERDICT_REJECT = 2'd2;

  // Reasons
  localparam logic [REASON_WIDTH-1:0] REASON_OK        = 3'd0;
  localparam logic [REASON_WIDTH-1:0] REASON_UNAVAIL   = 3'd1;
  localparam logic [REASON_WIDTH-1:0] REASON_INVALID   = 3'd2;
  localparam logic [REASON_WIDTH-1:0] REASON_TOO_LARGE = 3'd3;
  localparam logic [REASON_WIDTH-1:0] REASON_SHORT     = 3'd4;

  // ppm share: floor(total * ppm / 1e6), with 1e6 = 2^6 * 15625.
  // The product is shifted right by 6, then divided by 15625 one
  // 16-bit digit at a time using a reciprocal multiply per digit.
  localparam int HALF_WIDTH  = CREDIT_WIDTH / 2;
  localparam int PP_WIDTH    = HALF_WIDTH + PPM_WIDTH;
  localparam int PROD_WIDTH  = CREDIT_WIDTH + PPM_WIDTH;
  localparam int PRE_SHIFT   = 6;
  localparam int DIVISOR     = 15625;
  localparam int REM_WIDTH   = 14;
  localparam int DIGIT_WIDTH = 16;
  localparam int DIGITS      = (PROD_WIDTH - PRE_SHIFT + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int QUOT_WIDTH  = DIGITS * DIGIT_WIDTH;
  localparam int STEP_WIDTH  = REM_WIDTH + DIGIT_WIDTH;
  localparam int RECIP_SHIFT = STEP_WIDTH + REM_WIDTH;
  localparam int RECIP_WIDTH = 31;
  // ceil(2^44 / 15625); error term 2459 keeps the quotient exact below 2^30
  localparam logic [RECIP_WIDTH-1:0] RECIP = 31'd1125899907;
  localparam int MUL_WIDTH   = STEP_WIDTH + RECIP_WIDTH;

  // Pipeline stage map
  localparam int ST_IN    = 0;
  localparam int ST_PP    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_DIV   = 3;
  localparam int ST_SHARE = ST_DIV + 2 * DIGITS - 1;
  localparam int ST_EXTRA = ST_SHARE + 1;
  localparam int ST_LIMIT = ST_EXTRA + 1;
  localparam int STAGES   = ST_LIMIT + 1;

  // Request fields carried down the pipeline
  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic [STATE_WIDTH-1:0]  dstate;
    logic [CREDIT_WIDTH-1:0] total;
    logic [CREDIT_WIDTH-1:0] need;
    logic [TIME_WIDTH-1:0]   retry;
    logic                    lacks_credit;
  } item_t;

endpackage

// ===== hdl/cad_share.sv =====
// Pipelined overcommit share: floor(total * ppm / 1e6) plus overflow flag.
// Split multiply, product sum, then one reciprocal-multiply digit step per
// two stages. Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_share (
  input  logic                                   clk,
  input  logic [cad_pkg::ST_SHARE:cad_pkg::ST_PP] en,
  input  logic [cad_pkg::CREDIT_WIDTH-1:0]        total,
  input  logic [cad_pkg::PPM_WIDTH-1:0]           ppm,
  output logic [cad_pkg::CREDIT_WIDTH-1:0]        share,
  output logic                                    share_ovf
);

  logic [cad_pkg::PP_WIDTH-1:0]   pp_lo;
  logic [cad_pkg::PP_WIDTH-1:0]   pp_hi;
  logic [cad_pkg::PROD_WIDTH-1:0] prod_sum;
  logic [cad_pkg::QUOT_WIDTH-1:0] num0;

  logic [cad_pkg::QUOT_WIDTH-1:0]  a_num   [cad_pkg::DIGITS];
  logic [cad_pkg::STEP_WIDTH-1:0]  a_step  [cad_pkg::DIGITS];
  logic [cad_pkg::DIGIT_WIDTH-1:0] a_digit [cad_pkg::DIGITS];
  logic [cad_pkg::QUOT_WIDTH-1:0]  b_num   [cad_pkg::DIGITS];
  logic [cad_pkg::REM_WIDTH-1:0]   b_rem   [cad_pkg::DIGITS];

  assign prod_sum = (cad_pkg::PROD_WIDTH'(pp_hi) << cad_pkg::HALF_WIDTH)
                  + cad_pkg::PROD_WIDTH'(pp_lo);

  always_ff @(posedge clk) begin
    if (en[cad_pkg::ST_PP]) begin
      pp_lo <= cad_pkg::PP_WIDTH'(total[cad_pkg::HALF_WIDTH-1:0])
             * cad_pkg::PP_WIDTH'(ppm);
      pp_hi <= cad_pkg::PP_WIDTH'(total[cad_pkg::CREDIT_WIDTH-1:cad_pkg::HALF_WIDTH])
             * cad_pkg::PP_WIDTH'(ppm);
    end
    if (en[cad_pkg::ST_SUM]) begin
      num0 <= cad_pkg::QUOT_WIDTH'(prod_sum >> cad_pkg::PRE_SHIFT);
    end
  end

  // Each step consumes the top digit of the dividend and shifts a quotient
  // digit in at the bottom; after the last step the word is the quotient.
  for (genvar k = 0; k < cad_pkg::DIGITS; k++) begin : g_step
    logic [cad_pkg::QUOT_WIDTH-1:0] src_num;
    logic [cad_pkg::REM_WIDTH-1:0]  src_rem;
    logic [cad_pkg::STEP_WIDTH-1:0] step;
    logic [cad_pkg::MUL_WIDTH-1:0]  mul;
    logic [cad_pkg::STEP_WIDTH-1:0] back;

    if (k == 0) begin : g_first
      assign src_num = num0;
      assign src_rem = '0;
    end else begin : g_rest
      assign src_num = b_num[k-1];
      assign src_rem = b_rem[k-1];
    end

    assign step = {src_rem, src_num[cad_pkg::QUOT_WIDTH-1 -: cad_pkg::DIGIT_WIDTH]};
    assign mul  = cad_pkg::MUL_WIDTH'(step) * cad_pkg::MUL_WIDTH'(cad_pkg::RECIP);
    assign back = cad_pkg::STEP_WIDTH'(a_digit[k])
                * cad_pkg::STEP_WIDTH'(cad_pkg::DIVISOR);

    always_ff @(posedge clk) begin
      if (en[cad_pkg::ST_DIV + 2 * k]) begin
        a_num[k]   <= src_num;
        a_step[k]  <= step;
        a_digit[k] <= mul[cad_pkg::RECIP_SHIFT +: cad_pkg::DIGIT_WIDTH];
      end
      if (en[cad_pkg::ST_DIV + 2 * k + 1]) begin
        b_rem[k] <= cad_pkg::REM_WIDTH'(a_step[k] - back);
        b_num[k] <= {a_num[k][cad_pkg::QUOT_WIDTH-cad_pkg::DIGIT_WIDTH-1:0], a_digit[k]};
      end
    end
  end

  assign share     = b_num[cad_pkg::DIGITS-1][cad_pkg::CREDIT_WIDTH-1:0];
  assign share_ovf = |b_num[cad_pkg::DIGITS-1][cad_pkg::QUOT_WIDTH-1:cad_pkg::CREDIT_WIDTH];

endmodule

// ===== hdl/credit_admission_decision_core.sv =====
// Credit admission decision core, top level.
// Depends on cad_pkg and cad_share.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid/req_ready) takes one admission request per
//   transaction; response channel (rsp_valid/rsp_ready) returns exactly one
//   verdict per request, in order, with the request tag copied to tag_out.
//   Configuration is a write-only port (cfg_we, cfg_index, cfg_data); write
//   it only while no request is in flight.
// Datapath: a request passes through the input register, the ppm share path
//   (split multiply, sum, five two-stage digit steps of the divide by one
//   million), the allowance and limit stages and the output register.
// Throughput: one request per cycle, sustained while rsp_ready stays high.
// Stalls: each stage holds its contents while the next one is full and
//   blocked; empty stages keep filling, so req_ready drops only once every
//   stage and the output register hold a transaction.
// Reset: rst clears all stage valids, the response valid and the
//   configuration registers (overcommit off, TTL zero).
module credit_admission_decision_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [cad_pkg::TAG_WIDTH-1:0]       request_tag,
  input  logic [cad_pkg::STATE_WIDTH-1:0]     dev_state,
  input  logic [63:0]                         cap_credits,
  input  logic [63:0]                         available_credits,
  input  logic [63:0]                         need_credits,
  input  logic [cad_pkg::TIME_WIDTH-1:0]      now_time,
  input  logic [cad_pkg::TIME_WIDTH-1:0]      next_free_time,
  input  logic                                cfg_we,
  input  logic [cad_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [cad_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [cad_pkg::TAG_WIDTH-1:0]       tag_out,
  output logic [cad_pkg::VERDICT_WIDTH-1:0]   verdict,
  output logic [cad_pkg::REASON_WIDTH-1:0]    reason,
  output logic [cad_pkg::TIME_WIDTH-1:0]      retry_after,
  output logic [63:0]                         granted_credits,
  output logic [63:0]                         granted_ttl
);

  // Configuration registers
  logic                               oc_enable;
  logic [cad_pkg::CREDIT_WIDTH-1:0]   oc_fixed;
  logic [cad_pkg::PPM_WIDTH-1:0]      oc_ppm;
  logic [63:0]                        ttl_cfg;

  // Pipeline control
  logic [cad_pkg::STAGES-1:0] stage_valid;
  logic [cad_pkg::STAGES-1:0] stage_en;
  logic                       out_adv;

  // Input stage
  logic [cad_pkg::TAG_WIDTH-1:0]    s0_tag;
  logic [cad_pkg::STATE_WIDTH-1:0]  s0_dstate;
  logic [cad_pkg::CREDIT_WIDTH-1:0] s0_total;
  logic [cad_pkg::CREDIT_WIDTH-1:0] s0_avail;
  logic [cad_pkg::CREDIT_WIDTH-1:0] s0_need;
  logic [cad_pkg::TIME_WIDTH-1:0]   s0_now;
  logic [cad_pkg::TIME_WIDTH-1:0]   s0_next_free;

  cad_pkg::item_t pipe [cad_pkg::ST_PP:cad_pkg::ST_LIMIT];

  // Share path and limit stages
  logic [cad_pkg::CREDIT_WIDTH-1:0] share;
  logic                             share_ovf;
  logic [cad_pkg::CREDIT_WIDTH-1:0] share_eff;
  logic [cad_pkg::CREDIT_WIDTH-1:0] extra_next;
  logic                             ppm_set;
  logic [cad_pkg::CREDIT_WIDTH-1:0] s13_extra;
  logic                             s13_bad;
  logic [cad_pkg::CREDIT_WIDTH:0]   limit_sum;
  logic [cad_pkg::CREDIT_WIDTH-1:0] s14_limit;
  logic                             s14_bad;

  // Decision
  cad_pkg::item_t                    fin;
  logic [cad_pkg::VERDICT_WIDTH-1:0] verdict_next;
  logic [cad_pkg::REASON_WIDTH-1:0]  reason_next;
  logic [cad_pkg::TIME_WIDTH-1:0]    retry_next;
  logic [63:0]                       granted_next;
  logic [63:0]                       ttl_next;

  // ---------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      oc_enable <= 1'b0;
      oc_fixed  <= '0;
      oc_ppm    <= '0;
      ttl_cfg   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cad_pkg::CFG_OC_ENABLE: oc_enable <= cfg_data[0];
        cad_pkg::CFG_OC_FIXED:  oc_fixed  <= cfg_data[cad_pkg::CREDIT_WIDTH-1:0];
        cad_pkg::CFG_OC_PPM:    oc_ppm    <= cfg_data[cad_pkg::PPM_WIDTH-1:0];
        cad_pkg::CFG_GRANT_TTL: ttl_cfg   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: a stage may load when it or any stage after it is empty,
  // or the output register is free to move.
  assign out_adv   = !rsp_valid || rsp_ready;
  assign req_ready = stage_en[cad_pkg::ST_IN];

  for (genvar k = 0; k < cad_pkg::STAGES; k++) begin : g_en
    assign stage_en[k] = out_adv || !(&stage_valid[cad_pkg::STAGES-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[cad_pkg::ST_IN]) begin
        stage_valid[cad_pkg::ST_IN] <= req_valid;
      end
      for (int k = cad_pkg::ST_IN + 1; k < cad_pkg::STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  always_ff @(posedge clk) begin
    if (stage_en[cad_pkg::ST_IN]) begin
      s0_tag       <= request_tag;
      s0_dstate    <= dev_state;
      s0_total     <= cap_credits[cad_pkg::CREDIT_WIDTH-1:0];
      s0_avail     <= available_credits[cad_pkg::CREDIT_WIDTH-1:0];
      s0_need      <= need_credits[cad_pkg::CREDIT_WIDTH-1:0];
      s0_now       <= now_time;
      s0_next_free <= next_free_time;
    end
  end

  // Stage 1 folds the time and availability checks into the carried item
  always_ff @(posedge clk) begin
    if (stage_en[cad_pkg::ST_PP]) begin
      pipe[cad_pkg::ST_PP].tag          <= s0_tag;
      pipe[cad_pkg::ST_PP].dstate       <= s0_dstate;
      pipe[cad_pkg::ST_PP].total        <= s0_total;
      pipe[cad_pkg::ST_PP].need         <= s0_need;
      pipe[cad_pkg::ST_PP].retry        <= (s0_next_free > s0_now) ?
                                           (s0_next_free - s0_now) : '0;
      pipe[cad_pkg::ST_PP].lacks_credit <= s0_need > s0_avail;
    end
  end

  for (genvar k = cad_pkg::ST_PP + 1; k <= cad_pkg::ST_LIMIT; k++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (stage_en[k]) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Overcommit share
  cad_share u_share (
    .clk       (clk),
    .en        (stage_en[cad_pkg::ST_SHARE:cad_pkg::ST_PP]),
    .total     (s0_total),
    .ppm       (oc_ppm),
    .share     (share),
    .share_ovf (share_ovf)
  );

  // Allowance: smaller nonzero of fixed and ppm share, zero if disabled
  assign ppm_set   = oc_ppm != '0;
  assign share_eff = ppm_set ? share : '0;

  always_comb begin
    if (!oc_enable) begin
      extra_next = '0;
    end else if (oc_fixed == '0) begin
      extra_next = share_eff;
    end else if (share_eff == '0) begin
      extra_next = oc_fixed;
    end else begin
      extra_next = (oc_fixed < share_eff) ? oc_fixed : share_eff;
    end
  end

  assign limit_sum = {1'b0, pipe[cad_pkg::ST_LIMIT-1].total} + {1'b0, s13_extra};

  always_ff @(posedge clk) begin
    if (stage_en[cad_pkg::ST_EXTRA]) begin
      s13_extra <= extra_next;
      s13_bad   <= oc_enable && ppm_set && share_ovf;
    end
    if (stage_en[cad_pkg::ST_LIMIT]) begin
      s14_limit <= limit_sum[cad_pkg::CREDIT_WIDTH-1:0];
      s14_bad   <= s13_bad || limit_sum[cad_pkg::CREDIT_WIDTH];
    end
  end

  // ---------------------------------------------------------------------
  // Decision
  assign fin = pipe[cad_pkg::ST_LIMIT];

  always_comb begin
    verdict_next = cad_pkg::VERDICT_REJECT;
    reason_next  = cad_pkg::REASON_INVALID;
    retry_next   = '0;
    granted_next = '0;
    ttl_next     = '0;
    case (fin.dstate)
      cad_pkg::DEV_DRAINING: begin
        verdict_next = cad_pkg::VERDICT_DELAY;
        reason_next  = cad_pkg::REASON_UNAVAIL;
        retry_next   = fin.retry;
      end
      cad_pkg::DEV_MAINTENANCE, cad_pkg::DEV_UNAVAILABLE: begin
        reason_next = cad_pkg::REASON_UNAVAIL;
      end
      cad_pkg::DEV_AVAILABLE: begin
        if (fin.total == '0) begin
          reason_next = cad_pkg::REASON_TOO_LARGE;
        end else if (s14_bad) begin
          reason_next = cad_pkg::REASON_INVALID;
        end else if (fin.need > s14_limit) begin
          reason_next = cad_pkg::REASON_TOO_LARGE;
        end else if (fin.lacks_credit) begin
          verdict_next = cad_pkg::VERDICT_DELAY;
          reason_next  = cad_pkg::REASON_SHORT;
          retry_next   = fin.retry;
        end else begin
          verdict_next = cad_pkg::VERDICT_ACCEPT;
          reason_next  = cad_pkg::REASON_OK;
          granted_next = 64'(fin.need);
          ttl_next     = ttl_cfg;
        end
      end
      default: begin
        reason_next = cad_pkg::REASON_INVALID;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_adv) begin
      rsp_valid <= stage_valid[cad_pkg::ST_LIMIT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      tag_out         <= fin.tag;
      verdict         <= verdict_next;
      reason          <= reason_next;
      retry_after     <= retry_next;
      granted_credits <= granted_next;
      granted_ttl     <= ttl_next;
    end
  end

endmodule

// ===== test/cad_checker.sv =====
// Scoreboard for the credit admission decision core: snoops the config port
// and both channels, predicts each verdict and compares it in order.
// Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_ready,
  input  logic [cad_pkg::TAG_WIDTH-1:0]       request_tag,
  input  logic [cad_pkg::STATE_WIDTH-1:0]     dev_state,
  input  logic [63:0]                         cap_credits,
  input  logic [63:0]                         available_credits,
  input  logic [63:0]                         need_credits,
  input  logic [cad_pkg::TIME_WIDTH-1:0]      now_time,
  input  logic [cad_pkg::TIME_WIDTH-1:0]      next_free_time,
  input  logic                                cfg_we,
  input  logic [cad_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [cad_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                rsp_valid,
  input  logic                                rsp_ready,
  input  logic [cad_pkg::TAG_WIDTH-1:0]       tag_out,
  input  logic [cad_pkg::VERDICT_WIDTH-1:0]   verdict,
  input  logic [cad_pkg::REASON_WIDTH-1:0]    reason,
  input  logic [cad_pkg::TIME_WIDTH-1:0]      retry_after,
  input  logic [63:0]                         granted_credits,
  input  logic [63:0]                         granted_ttl,
  output int                                  pending,
  output int                                  fail_count
);

  localparam logic [127:0] PPM_SCALE = 128'd1000000;

  typedef struct packed {
    logic [cad_pkg::TAG_WIDTH-1:0]     tag;
    logic [cad_pkg::VERDICT_WIDTH-1:0] verdict;
    logic [cad_pkg::REASON_WIDTH-1:0]  reason;
    logic [cad_pkg::TIME_WIDTH-1:0]    retry;
    logic [63:0]                       granted;
    logic [63:0]                       ttl;
  } decision_t;

  logic                          oc_enable;
  logic [63:0]                   oc_fixed;
  logic [cad_pkg::PPM_WIDTH-1:0] oc_ppm;
  logic [63:0]                   ttl_cfg;
  decision_t                     decision_q[$];
  decision_t                     want;
  int                            fail_cnt = 0;

  assign fail_count = fail_cnt;

  function automatic logic [63:0] wait_time(input logic [63:0] now_t, next_t);
    return (next_t > now_t) ? next_t - now_t : 64'd0;
  endfunction

  function automatic decision_t decide(
    input logic [cad_pkg::TAG_WIDTH-1:0]   tag,
    input logic [cad_pkg::STATE_WIDTH-1:0] dstate,
    input logic [63:0]                     total,
    input logic [63:0]                     avail,
    input logic [63:0]                     need,
    input logic [63:0]                     now_t,
    input logic [63:0]                     next_t
  );
    logic [127:0] prod;
    logic [127:0] quot;
    logic [63:0]  share;
    logic [63:0]  extra;
    logic [64:0]  limit;
    logic         limit_ok;
    decision_t    d;

    d = '0;
    d.tag = tag;
    d.verdict = cad_pkg::VERDICT_REJECT;
    d.reason = cad_pkg::REASON_INVALID;
    limit = {1'b0, total};
    limit_ok = 1'b1;
    if (oc_enable) begin
      prod = {64'd0, total} * {108'd0, oc_ppm};
      quot = prod / PPM_SCALE;
      share = quot[63:0];
      if (quot[127:64] != '0) limit_ok = 1'b0;
      if (oc_fixed == '0) extra = share;
      else if (share == '0) extra = oc_fixed;
      else extra = (oc_fixed < share) ? oc_fixed : share;
      limit = {1'b0, total} + {1'b0, extra};
      // limit must fit the credit width
      if (limit[64]) limit_ok = 1'b0;
    end

    if (dstate == cad_pkg::DEV_DRAINING) begin
      d.verdict = cad_pkg::VERDICT_DELAY;
      d.reason = cad_pkg::REASON_UNAVAIL;
      d.retry = wait_time(now_t, next_t);
    end else if (dstate == cad_pkg::DEV_MAINTENANCE ||
                 dstate == cad_pkg::DEV_UNAVAILABLE) begin
      d.reason = cad_pkg::REASON_UNAVAIL;
    end else if (dstate != cad_pkg::DEV_AVAILABLE) begin
      d.reason = cad_pkg::REASON_INVALID;
    end else if (total == '0) begin
      d.reason = cad_pkg::REASON_TOO_LARGE;
    end else if (!limit_ok) begin
      d.reason = cad_pkg::REASON_INVALID;
    end else if ({1'b0, need} > limit) begin
      d.reason = cad_pkg::REASON_TOO_LARGE;
    end else if (need > avail) begin
      d.verdict = cad_pkg::VERDICT_DELAY;
      d.reason = cad_pkg::REASON_SHORT;
      d.retry = wait_time(now_t, next_t);
    end else begin
      d.verdict = cad_pkg::VERDICT_ACCEPT;
      d.reason = cad_pkg::REASON_OK;
      d.granted = need;
      d.ttl = ttl_cfg;
    end
    return d;
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, want_v);
    if (got !== want_v)
      report($sformatf("tag %h %s: got %h, expected %h", want.tag, name, got, want_v));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      oc_enable <= 1'b0;
      oc_fixed <= '0;
      oc_ppm <= '0;
      ttl_cfg <= '0;
      decision_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (decision_q.size() == 0) begin
          report($sformatf("response tag %h with no request outstanding", tag_out));
        end else begin
          want = decision_q.pop_front();
          check_field("tag_out", tag_out, want.tag);
          check_field("verdict", verdict, want.verdict);
          check_field("reason", reason, want.reason);
          check_field("retry_after", retry_after, want.retry);
          check_field("granted_credits", granted_credits, want.granted);
          check_field("granted_ttl", granted_ttl, want.ttl);
        end
      end
      if (req_valid && req_ready)
        decision_q.push_back(decide(request_tag, dev_state, cap_credits,
                                    available_credits, need_credits,
                                    now_time, next_free_time));
      if (cfg_we) begin
        case (cfg_index)
          cad_pkg::CFG_OC_ENABLE: oc_enable <= cfg_data[0];
          cad_pkg::CFG_OC_FIXED:  oc_fixed <= cfg_data;
          cad_pkg::CFG_OC_PPM:    oc_ppm <= cfg_data[cad_pkg::PPM_WIDTH-1:0];
          cad_pkg::CFG_GRANT_TTL: ttl_cfg <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= decision_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the credit admission decision testbench: clock, reset, config
// writes, request stimulus with random idling, and the verdict.
// Depends on cad_pkg, cad_checker and credit_admission_decision_core.
`timescale 1ns / 1ps

module tb;

  localparam int                            CYCLE_LIMIT   = 200000;
  localparam int                            DRAIN_CYCLES  = 20;
  localparam int                            PHASES        = 6;
  localparam int                            PHASE_ITEMS   = 85;
  localparam int                            EN_PAD_WIDTH  = cad_pkg::CFG_DATA_WIDTH - 1;
  localparam int                            PPM_PAD_WIDTH = cad_pkg::CFG_DATA_WIDTH
                                                          - cad_pkg::PPM_WIDTH;
  localparam logic [63:0]                   CMAX          = '1;
  localparam logic [cad_pkg::PPM_WIDTH-1:0] PPM_ONE       = 20'd1000000;
  localparam logic [cad_pkg::PPM_WIDTH-1:0] PPM_MAX       = '1;
  // codes outside the defined device states
  localparam logic [cad_pkg::STATE_WIDTH-1:0] DEV_UNKNOWN_LO = 3'd4;
  localparam logic [cad_pkg::STATE_WIDTH-1:0] DEV_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [63:0]                     tag;
    logic [cad_pkg::STATE_WIDTH-1:0] dstate;
    logic [63:0]                     total;
    logic [63:0]                     avail;
    logic [63:0]                     need;
    logic [63:0]                     now_t;
    logic [63:0]                     next_t;
  } request_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_ready;
  logic [cad_pkg::TAG_WIDTH-1:0]       request_tag = '0;
  logic [cad_pkg::STATE_WIDTH-1:0]     dev_state = '0;
  logic [63:0]                         cap_credits = '0;
  logic [63:0]                         available_credits = '0;
  logic [63:0]                         need_credits = '0;
  logic [cad_pkg::TIME_WIDTH-1:0]      now_time = '0;
  logic [cad_pkg::TIME_WIDTH-1:0]      next_free_time = '0;
  logic                                cfg_we = 1'b0;
  logic [cad_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [cad_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                                rsp_valid;
  logic                                rsp_ready = 1'b0;
  logic [cad_pkg::TAG_WIDTH-1:0]       tag_out;
  logic [cad_pkg::VERDICT_WIDTH-1:0]   verdict;
  logic [cad_pkg::REASON_WIDTH-1:0]    reason;
  logic [cad_pkg::TIME_WIDTH-1:0]      retry_after;
  logic [63:0]                         granted_credits;
  logic [63:0]                         granted_ttl;
  logic                                quiet = 1'b0;
  int                                  pending;
  int                                  fail_count;
  int                                  cycles = 0;

  credit_admission_decision_core dut (
    .clk, .rst, .req_valid, .req_ready, .request_tag, .dev_state,
    .cap_credits, .available_credits, .need_credits, .now_time,
    .next_free_time, .cfg_we, .cfg_index, .cfg_data, .rsp_valid, .rsp_ready,
    .tag_out, .verdict, .reason, .retry_after, .granted_credits, .granted_ttl
  );

  cad_checker u_checker (
    .clk, .rst, .req_valid, .req_ready, .request_tag, .dev_state,
    .cap_credits, .available_credits, .need_credits, .now_time,
    .next_free_time, .cfg_we, .cfg_index, .cfg_data, .rsp_valid, .rsp_ready,
    .tag_out, .verdict, .reason, .retry_after, .granted_credits, .granted_ttl,
    .pending, .fail_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // response side backpressure
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= quiet || ($urandom_range(99) >= 15);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_credit();
    case ($urandom_range(4))
      0: return 64'($urandom_range(2000));
      1: return 64'($urandom);
      2: return rand64();
      3: return CMAX - 64'($urandom_range(3));
      default: return rand64() >> $urandom_range(63);
    endcase
  endfunction

  function automatic request_t mk(input logic [cad_pkg::STATE_WIDTH-1:0] dstate,
                                 input logic [63:0] total, avail, need, now_t, next_t);
    request_t r;
    r.tag = rand64();
    r.dstate = dstate;
    r.total = total;
    r.avail = avail;
    r.need = need;
    r.now_t = now_t;
    r.next_t = next_t;
    return r;
  endfunction

  task automatic send_req(input request_t r);
    if (!quiet) begin
      while ($urandom_range(99) < 15) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    request_tag <= r.tag;
    dev_state <= r.dstate;
    cap_credits <= r.total;
    available_credits <= r.avail;
    need_credits <= r.need;
    now_time <= r.now_t;
    next_free_time <= r.next_t;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // upper data bits of the narrow registers carry junk on purpose
  task automatic write_config(input logic en, input logic [63:0] fixed,
                              input logic [cad_pkg::PPM_WIDTH-1:0] ppm,
                              input logic [63:0] ttl);
    cfg_we <= 1'b1;
    cfg_index <= cad_pkg::CFG_OC_ENABLE;
    cfg_data <= {EN_PAD_WIDTH'(rand64()), en};
    @(posedge clk);
    cfg_index <= cad_pkg::CFG_OC_FIXED;
    cfg_data <= fixed;
    @(posedge clk);
    cfg_index <= cad_pkg::CFG_OC_PPM;
    cfg_data <= {PPM_PAD_WIDTH'(rand64()), ppm};
    @(posedge clk);
    cfg_index <= cad_pkg::CFG_GRANT_TTL;
    cfg_data <= ttl;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    request_t                      r;
    logic                          en;
    logic [63:0]                   fixed;
    logic [cad_pkg::PPM_WIDTH-1:0] ppm;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: no overcommit, zero TTL
    send_req(mk(cad_pkg::DEV_DRAINING, 100, 100, 10, 1000, 5000));
    send_req(mk(cad_pkg::DEV_DRAINING, 100, 100, 10, 5000, 1000));
    send_req(mk(cad_pkg::DEV_MAINTENANCE, 100, 100, 10, 0, 10));
    send_req(mk(cad_pkg::DEV_UNAVAILABLE, 100, 100, 10, 0, 10));
    send_req(mk(DEV_UNKNOWN_LO, 100, 100, 10, 0, 10));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 0, CMAX, 1, 0, 10));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 100, 200, 101, 0, 10));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 100, 50, 60, 0, CMAX));
    send_req(mk(cad_pkg::DEV_AVAILABLE, CMAX, CMAX, CMAX, CMAX, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1, 0, 0, 0, 0));

    drain();
    write_config(1'b1, 64'd0, PPM_ONE, CMAX);
    send_req(mk(cad_pkg::DEV_AVAILABLE, CMAX, CMAX, 1, 0, 0));        // limit overflows
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1000, 5000, 2000, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1000, 5000, 2001, 0, 0));

    drain();
    write_config(1'b1, 64'd5, PPM_MAX, 64'd123);
    send_req(mk(cad_pkg::DEV_AVAILABLE, CMAX, CMAX, 1, 0, 0));        // ppm share too wide
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1000, 2000, 1005, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1000, 2000, 1006, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1, 10, 2, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1, 10, 3, 0, 0));

    drain();
    write_config(1'b1, CMAX, '0, 64'd0);
    send_req(mk(cad_pkg::DEV_AVAILABLE, 1, CMAX, 1, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 0, CMAX, 0, 0, 0));

    drain();
    write_config(1'b0, CMAX, PPM_MAX, CMAX);
    send_req(mk(cad_pkg::DEV_AVAILABLE, CMAX, CMAX, CMAX, 0, 0));
    send_req(mk(DEV_UNKNOWN_HI, CMAX, CMAX, CMAX, 0, 0));

    drain();
    write_config(1'b1, 64'd0, '0, 64'd1);
    send_req(mk(cad_pkg::DEV_AVAILABLE, 10, 20, 11, 0, 0));
    send_req(mk(cad_pkg::DEV_AVAILABLE, 10, 20, 10, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      en = ($urandom_range(3) != 0);
      case ($urandom_range(3))
        0: fixed = '0;
        1: fixed = 64'($urandom_range(1, 5000));
        2: fixed = rand64() >> $urandom_range(63);
        default: fixed = CMAX;
      endcase
      case ($urandom_range(4))
        0: ppm = '0;
        1: ppm = cad_pkg::PPM_WIDTH'($urandom_range(1, 1000));
        2: ppm = PPM_ONE;
        3: ppm = cad_pkg::PPM_WIDTH'($urandom);
        default: ppm = PPM_MAX;
      endcase
      write_config(en, fixed, ppm, rand64());
      quiet <= (ph == 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) drain();
        r.tag = rand64();
        r.dstate = ($urandom_range(9) < 7) ? cad_pkg::DEV_AVAILABLE
                                           : cad_pkg::STATE_WIDTH'($urandom);
        r.total = ($urandom_range(19) == 0) ? 64'd0 : pick_credit();
        // keep need near the limit so every decision branch gets hit
        case ($urandom_range(5))
          0: r.need = r.total;
          1: r.need = r.total + 64'($urandom_range(3));
          2: r.need = r.total - 64'($urandom_range(3));
          3: r.need = r.total + (r.total >> $urandom_range(1, 20));
          4: r.need = r.total >> $urandom_range(8);
          default: r.need = pick_credit();
        endcase
        case ($urandom_range(3))
          0: r.avail = r.need;
          1: r.avail = r.need - 64'($urandom_range(1, 3));
          2: r.avail = r.need + 64'($urandom_range(1000));
          default: r.avail = pick_credit();
        endcase
        r.now_t = rand64();
        case ($urandom_range(3))
          0, 1: r.next_t = r.now_t + 64'($urandom);
          2: r.next_t = r.now_t - 64'($urandom_range(1000));
          default: r.next_t = rand64();
        endcase
        send_req(r);
      end
    end

    drain();
    quiet <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cad_pkg.sv
hdl/cad_share.sv
hdl/credit_admission_decision_core.sv
test/cad_checker.sv
test/tb.sv
